[hdl/e2dir_pkg.sv]
`default_nettype none

package e2dir_pkg;

    typedef logic [1:0] kind_t;

    // result kinds
    localparam kind_t KIND_NAME   = 2'd0;
    localparam kind_t KIND_EMPTY  = 2'd1;
    localparam kind_t KIND_BADLEN = 2'd2;

    // parse phase codes
    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    // ext2 record layout
    localparam int HDR_BYTES  = 8;
    localparam int MIN_RECORD = 12;

endpackage

`default_nettype wire

[hdl/ext2_dir_entry_parser.sv]
`default_nettype none

// ext2 directory record parser. Directory block bytes enter one per transaction on the
// s_ channel, blocks of BLOCK_BYTES back to back; s_first_of_dir restarts the position
// at a new directory. Every record with a nonzero inode gives its name one byte per m_
// transaction, tagged with the inode, with m_name_end on the last byte. A record with an
// empty name and a nonzero inode gives one kind 1 marker; a record length that is not
// a multiple of four gives one kind 2 error and the rest of the block is skipped. Records
// that do not fit, or are shorter than 12 bytes, skip the rest of the block without a
// result. The block takes one byte per clock cycle while no result waits on m_ready,
// and each byte gives at most one result. An accepted byte passes through the input
// register, then the parser state update and the result register. This rate is set by
// the parser state loop (offsets, header fields, skip flag), which handles every byte
// in one pass. While a result waits on m_ready the input register holds one more byte
// and s_ready stays low until the result is taken.

module ext2_dir_entry_parser #(
    parameter int BLOCK_BYTES = 1024
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [7:0]         s_data_byte,
    input  wire                s_first_of_dir,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [7:0]         m_name_char,
    output logic [31:0]        m_entry_inode,
    output logic               m_name_end,
    output e2dir_pkg::kind_t   m_kind
);
    import e2dir_pkg::*;

    localparam int OFF_W      = $clog2(BLOCK_BYTES);
    localparam int LAST_START = BLOCK_BYTES - MIN_RECORD;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    // parser state
    logic [OFF_W-1:0] block_offset_reg, block_offset_next;
    logic [OFF_W-1:0] record_offset_reg, record_offset_next;
    logic [31:0]      header_inode_reg, header_inode_next;
    logic [15:0]      record_length_reg, record_length_next;
    logic [7:0]       name_length_reg, name_length_next;
    logic             phase_reg, phase_next;
    logic             skip_reg, skip_next;

    // result register
    logic        m_valid_reg;
    logic [7:0]  name_char_reg;
    logic [31:0] entry_inode_reg;
    logic        name_end_reg;
    kind_t       kind_reg;

    // result of the current byte
    logic        emit;
    logic [7:0]  res_char;
    logic        res_end;
    kind_t       res_kind;

    // helpers
    logic             process;
    logic [OFF_W-1:0] blk, roff, idx;
    logic             phase_eff, skip_eff;
    logic [OFF_W:0]   blk_inc, roff_inc;
    logic [16:0]      rec_reach;
    logic [15:0]      rl_body;
    logic [7:0]       nl_clamped;

    // a byte moves through when the result register can take whatever it gives
    assign process = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_of_dir;
        end
    end

    always_comb begin
        // a new directory restarts position before the byte is handled
        blk       = in_first_reg ? '0 : block_offset_reg;
        roff      = in_first_reg ? '0 : record_offset_reg;
        phase_eff = in_first_reg ? PH_HEADER : phase_reg;
        skip_eff  = in_first_reg ? 1'b0 : skip_reg;

        header_inode_next  = header_inode_reg;
        record_length_next = record_length_reg;
        name_length_next   = name_length_reg;
        record_offset_next = roff;
        phase_next         = phase_eff;
        skip_next          = skip_eff;

        emit     = 1'b0;
        res_char = 8'd0;
        res_end  = 1'b1;
        res_kind = KIND_NAME;

        idx        = roff - OFF_W'(HDR_BYTES);
        roff_inc   = {1'b0, roff} + (OFF_W+1)'(1);
        rec_reach  = 17'(blk) + {1'b0, record_length_reg};
        rl_body    = record_length_reg - 16'(HDR_BYTES);
        nl_clamped = name_length_reg;

        if (!skip_eff) begin
            if (phase_eff == PH_HEADER) begin
                if (roff == '0 && blk > OFF_W'(LAST_START)) begin
                    // no room left in the block for a record
                    skip_next = 1'b1;
                end else begin
                    // little-endian header fields; byte 7 is the type and ignored
                    case (roff[2:0])
                        3'd0: begin
                            header_inode_next  = {24'd0, in_byte_reg};
                            record_length_next = 16'd0;
                            name_length_next   = 8'd0;
                        end
                        3'd1: header_inode_next[15:8]  = in_byte_reg;
                        3'd2: header_inode_next[23:16] = in_byte_reg;
                        3'd3: header_inode_next[31:24] = in_byte_reg;
                        3'd4: record_length_next[7:0]  = in_byte_reg;
                        3'd5: record_length_next[15:8] = in_byte_reg;
                        3'd6: name_length_next         = in_byte_reg;
                        default: ;
                    endcase

                    if (roff[2:0] != 3'd7) begin
                        record_offset_next = roff + OFF_W'(1);
                    end else if (record_length_reg < 16'(MIN_RECORD) ||
                                 rec_reach > 17'(BLOCK_BYTES + HDR_BYTES - 1)) begin
                        // record too short or runs past the block end
                        skip_next = 1'b1;
                    end else if (record_length_reg[1:0] != 2'b00) begin
                        skip_next = 1'b1;
                        emit      = 1'b1;
                        res_kind  = KIND_BADLEN;
                    end else begin
                        if ({8'd0, name_length_reg} > rl_body) begin
                            nl_clamped = rl_body[7:0];
                        end
                        name_length_next   = nl_clamped;
                        phase_next         = PH_BODY;
                        record_offset_next = OFF_W'(HDR_BYTES);
                        if (header_inode_reg != 32'd0 && nl_clamped == 8'd0) begin
                            emit     = 1'b1;
                            res_kind = KIND_EMPTY;
                        end
                    end
                end
            end else begin
                if (header_inode_reg != 32'd0 && idx < OFF_W'(name_length_reg)) begin
                    emit     = 1'b1;
                    res_char = in_byte_reg;
                    res_end  = (idx + OFF_W'(1)) == OFF_W'(name_length_reg);
                    res_kind = KIND_NAME;
                end
                record_offset_next = roff_inc[OFF_W-1:0];
                if (16'(roff_inc) >= record_length_reg) begin
                    phase_next         = PH_HEADER;
                    record_offset_next = '0;
                end
            end
        end

        // block boundary restarts position and clears a pending skip
        blk_inc           = {1'b0, blk} + (OFF_W+1)'(1);
        block_offset_next = blk_inc[OFF_W-1:0];
        if (blk_inc >= (OFF_W+1)'(BLOCK_BYTES)) begin
            block_offset_next  = '0;
            record_offset_next = '0;
            phase_next         = PH_HEADER;
            skip_next          = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_offset_reg  <= '0;
            record_offset_reg <= '0;
            header_inode_reg  <= 32'd0;
            record_length_reg <= 16'd0;
            name_length_reg   <= 8'd0;
            phase_reg         <= PH_HEADER;
            skip_reg          <= 1'b0;
        end else if (process) begin
            block_offset_reg  <= block_offset_next;
            record_offset_reg <= record_offset_next;
            header_inode_reg  <= header_inode_next;
            record_length_reg <= record_length_next;
            name_length_reg   <= name_length_next;
            phase_reg         <= phase_next;
            skip_reg          <= skip_next;
        end
    end

    // result register, refilled when empty or taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            m_valid_reg <= process && emit;
        end
        if (process && emit) begin
            name_char_reg   <= res_char;
            entry_inode_reg <= header_inode_reg;
            name_end_reg    <= res_end;
            kind_reg        <= res_kind;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_name_char   = name_char_reg;
    assign m_entry_inode = entry_inode_reg;
    assign m_name_end    = name_end_reg;
    assign m_kind        = kind_reg;

endmodule

`default_nettype wire

[hdl/e2dir_checker.sv]
`default_nettype none

module e2dir_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input wire  [7:0]         s_data_byte,
    input wire                s_first_of_dir,
    input wire                m_valid,
    input wire                m_ready,
    input wire  [7:0]         m_name_char,
    input wire  [31:0]        m_entry_inode,
    input wire                m_name_end,
    input wire e2dir_pkg::kind_t m_kind
);
    import e2dir_pkg::*;

    // offered byte holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) &&
            $stable(s_first_of_dir))
        else $error("input changed while stalled");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_name_char) &&
            $stable(m_entry_inode) && $stable(m_name_end) && $stable(m_kind))
        else $error("result changed while stalled");

    // markers and errors carry no name byte and close the entry
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_NAME |-> m_name_end && m_name_char == 8'd0)
        else $error("marker result with name byte or open entry");

    // only records with a nonzero inode report names or empty markers
    a_inode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_NAME || m_kind == KIND_EMPTY) |-> m_entry_inode != 32'd0)
        else $error("name reported for zero inode");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ext2_dir_entry_parser e2dir_checker u_e2dir_checker (.*);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import e2dir_pkg::*;

    // directory block size, kept equal to the dut parameter
    localparam int DIR_BLOCK = 1024;
    // long receiver hold-off that lets the dut fill up and stall its input
    localparam int HOLD_CYCLES = 300;
    // cycles allowed after the last expected result, longer than any random receiver stall
    localparam int DRAIN_CYCLES = 80;
    // generous wall for the whole run, in ns
    localparam int TIMEOUT_NS = 60_000_000;

    // one result transaction as the dut should present it
    typedef struct packed {
        logic [7:0]  name_char;
        logic [31:0] entry_inode;
        logic        name_end;
        kind_t       kind;
    } name_result_t;

    // clock, reset and dut ports; the ones driven here are known from time zero
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = '0;
    logic        s_first_of_dir = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_name_char;
    logic [31:0] m_entry_inode;
    logic        m_name_end;
    kind_t       m_kind;

    // name bytes and markers the parser still owes us, oldest first
    name_result_t names_due[$];
    int           mismatches = 0;
    // bytes the parser actually looked at (not inside a skipped block tail)
    int           live_bytes = 0;
    // random idling on both channels when set
    bit           idle_on = 1'b1;
    // request from a test for one long receiver hold-off
    bit           drain_hold = 1'b0;

    // parser state as we track it
    int unsigned  blk_off   = 0;
    int unsigned  rec_off   = 0;
    logic [31:0]  hdr_inode = '0;
    logic [15:0]  rec_len   = '0;
    logic [7:0]   name_len  = '0;
    logic         phase     = PH_HEADER;
    logic         skipping  = 1'b0;

    ext2_dir_entry_parser #(
        .BLOCK_BYTES    (DIR_BLOCK)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first_of_dir (s_first_of_dir),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_char    (m_name_char),
        .m_entry_inode  (m_entry_inode),
        .m_name_end     (m_name_end),
        .m_kind         (m_kind)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // position and phase restart at a block boundary or a new directory
    function automatic void restart_block();
        blk_off  = 0;
        rec_off  = 0;
        phase    = PH_HEADER;
        skipping = 1'b0;
    endfunction

    function automatic void owe_result(logic [7:0] ch, logic last, kind_t k);
        name_result_t r;
        r.name_char   = ch;
        r.entry_inode = hdr_inode;
        r.name_end    = last;
        r.kind        = k;
        names_due.push_back(r);
    endfunction

    // advance the tracked parser by one accepted byte; returns 1 if the byte was looked at
    function automatic bit parse_dir_byte(logic [7:0] b, logic first);
        bit          live;
        int unsigned start;
        int unsigned idx;
        if (first) restart_block();
        live = !skipping;
        if (!skipping) begin
            if (phase == PH_HEADER) begin
                if (rec_off == 0 && blk_off + MIN_RECORD > DIR_BLOCK) begin
                    // not enough room left in the block for a record
                    skipping = 1'b1;
                end else begin
                    if (rec_off == 0) begin
                        hdr_inode = '0;
                        rec_len   = '0;
                        name_len  = '0;
                    end
                    // little-endian header fields
                    if (rec_off < 4) hdr_inode[8*rec_off +: 8] = b;
                    else if (rec_off < 6) rec_len[8*(rec_off-4) +: 8] = b;
                    else if (rec_off == 6) name_len = b;
                    if (rec_off < HDR_BYTES - 1) begin
                        rec_off++;
                    end else begin
                        start = blk_off - (HDR_BYTES - 1);
                        if (rec_len < MIN_RECORD || start + rec_len > DIR_BLOCK) begin
                            // too short or runs past the block: silent skip
                            skipping = 1'b1;
                        end else if (rec_len[1:0] != 2'b00) begin
                            // misaligned length: error marker, then skip
                            skipping = 1'b1;
                            owe_result(8'h00, 1'b1, KIND_BADLEN);
                        end else begin
                            if (name_len > rec_len - HDR_BYTES)
                                name_len = 8'(rec_len - HDR_BYTES);
                            phase   = PH_BODY;
                            rec_off = HDR_BYTES;
                            if (hdr_inode != 0 && name_len == 0)
                                owe_result(8'h00, 1'b1, KIND_EMPTY);
                        end
                    end
                end
            end else begin
                idx = rec_off - HDR_BYTES;
                if (hdr_inode != 0 && idx < name_len)
                    owe_result(b, idx + 1 == name_len, KIND_NAME);
                rec_off++;
                if (rec_off >= rec_len) begin
                    phase   = PH_HEADER;
                    rec_off = 0;
                end
            end
        end
        blk_off++;
        if (blk_off >= DIR_BLOCK) restart_block();
        return live;
    endfunction

    // offer one byte, hold it until accepted, then account for it
    task automatic push_dir_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_first_of_dir <= first;
        do @(posedge aclk); while (!s_ready);
        if (parse_dir_byte(b, first)) live_bytes++;
    endtask

    // one record: 8 header bytes, then body bytes with random content
    task automatic put_record(input logic first, input logic [31:0] ino,
                              input logic [15:0] len, input logic [7:0] nlen, input int body);
        for (int i = 0; i < 4; i++) push_dir_byte(ino[8*i +: 8], first && (i == 0));
        push_dir_byte(len[7:0], 1'b0);
        push_dir_byte(len[15:8], 1'b0);
        push_dir_byte(nlen, 1'b0);
        // file type byte, never looked at
        push_dir_byte(8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < body; i++) push_dir_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // a random record; clean keeps it well formed, otherwise some are broken or noise
    task automatic put_mixed_record(input logic first, input bit clean, output bit broken);
        int          pick;
        int          len;
        int          nlen;
        int          body;
        int          room;
        logic [31:0] ino;
        pick   = $urandom_range(0, clean ? 19 : 99);
        // a new directory starts at the head of a block
        room   = first ? DIR_BLOCK : DIR_BLOCK - blk_off;
        ino    = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 4095);
        if (ino == 0) ino = 1;
        nlen   = $urandom_range(1, 24);
        len    = (HDR_BYTES + nlen + 3) / 4 * 4 + 4 * $urandom_range(0, 2);
        broken = 1'b0;
        if (pick < 8) begin
            // nonzero inode with an empty name
            nlen = 0;
        end else if (pick < 14) begin
            // unused slot
            ino = '0;
        end else if (pick < 20) begin
            // name length longer than the record allows
            nlen = $urandom_range(len - HDR_BYTES + 1, 255);
        end else if (pick < 27) begin
            // length not a multiple of four
            len = 4 * $urandom_range(3, 10) + $urandom_range(1, 3);
        end else if (pick < 32) begin
            len = $urandom_range(0, MIN_RECORD - 1);
        end else if (pick < 36) begin
            len = room + 4 * $urandom_range(1, 64);
        end else if (pick < 40) begin
            // raw noise in place of a record
            body = $urandom_range(1, 16);
            for (int i = 0; i < body; i++)
                push_dir_byte(8'($urandom_range(0, 255)), first && (i == 0));
            broken = 1'b1;
            return;
        end
        if (pick >= 20 && pick < 36) begin
            // the block tail is skipped, a few bytes of it are enough
            broken = 1'b1;
            body   = $urandom_range(0, 3);
        end else if (pick >= 40 && pick < 46) begin
            // cut short, the next directory starts mid-record
            broken = 1'b1;
            body   = $urandom_range(0, len - HDR_BYTES - 1);
        end else begin
            body = len - HDR_BYTES;
        end
        put_record(first, ino, 16'(len), 8'(nlen), body);
    endtask

    // extremes of the fields, empty name, misaligned length with zero inode
    task automatic test_directed();
        logic [8:0] seq[$];
        idle_on = 1'b1;
        // bit 8 is first_of_dir, low byte is the data
        seq = '{9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h00C, 9'h000, 9'h004, 9'h001,
                9'h0FF, 9'h000, 9'h0A5, 9'h05A,
                9'h101, 9'h000, 9'h000, 9'h000, 9'h00C, 9'h000, 9'h000, 9'h002,
                9'h100, 9'h000, 9'h000, 9'h000, 9'h00E, 9'h000, 9'h003, 9'h000,
                9'h0AA};
        foreach (seq[i]) push_dir_byte(seq[i][7:0], seq[i][8]);
    endtask

    // receiver holds off while a long name streams in
    task automatic test_hold_off();
        idle_on    = 1'b0;
        drain_hold = 1'b1;
        put_record(1'b1, $urandom | 32'h1, 16'd68, 8'd60, 60);
    endtask

    // many short directories of mixed records
    task automatic test_random_dirs(input int target);
        int stop_at;
        int n;
        bit broken;
        stop_at = live_bytes + target;
        while (live_bytes < stop_at) begin
            idle_on = ($urandom_range(0, 4) != 0);
            n       = $urandom_range(1, 6);
            broken  = 1'b0;
            for (int i = 0; i < n && !broken; i++) put_mixed_record(i == 0, 1'b0, broken);
        end
    endtask

    // one directory across a block end: no room left, exact fit or a record past the end
    task automatic test_block_end();
        bit          broken;
        logic        first;
        int          room;
        int          pad;
        int          pick;
        logic [31:0] ino;
        idle_on = 1'b1;
        first   = 1'b1;
        pick    = $urandom_range(0, 2);
        while (first || DIR_BLOCK - blk_off >= 64) begin
            put_mixed_record(first, 1'b1, broken);
            first = 1'b0;
        end
        room = DIR_BLOCK - blk_off;
        ino  = $urandom | 32'h1;
        case (pick)
            0: begin
                // leave 4 or 8 bytes, too few for another record
                pad = 4 * $urandom_range(1, 2);
                put_record(1'b0, ino, 16'(room - pad), 8'($urandom_range(0, 8)),
                           room - pad - HDR_BYTES);
                repeat (pad) push_dir_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            1: begin
                // last record ends exactly at the block end
                put_record(1'b0, ino, 16'(room), 8'($urandom_range(0, 16)),
                           room - HDR_BYTES);
            end
            default: begin
                // record claims 4 bytes more than the block has
                put_record(1'b0, ino, 16'(room + 4), 8'd3, 0);
                repeat (room - HDR_BYTES) push_dir_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
        // a couple of records in the next block, skip must have cleared
        put_mixed_record(1'b0, 1'b1, broken);
        put_mixed_record(1'b0, 1'b1, broken);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin : result_drain
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (drain_hold) begin
                drain_hold = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // compare every result transaction against the oldest owed one
    always @(posedge aclk) begin
        name_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (names_due.size() == 0) begin
                $error("unexpected result: name_char %h inode %h end %b kind %0d",
                       m_name_char, m_entry_inode, m_name_end, m_kind);
                mismatches++;
            end else begin
                want = names_due.pop_front();
                if (m_name_char !== want.name_char) begin
                    $error("name_char: expected %h, got %h", want.name_char, m_name_char);
                    mismatches++;
                end
                if (m_entry_inode !== want.entry_inode) begin
                    $error("entry_inode: expected %h, got %h", want.entry_inode, m_entry_inode);
                    mismatches++;
                end
                if (m_name_end !== want.name_end) begin
                    $error("name_end: expected %b, got %b", want.name_end, m_name_end);
                    mismatches++;
                end
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    mismatches++;
                end
            end
        end
    end

    // test sequence
    initial begin : main_seq
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_hold_off();
        test_random_dirs(40);
        test_block_end();
        s_valid <= 1'b0;
        // no new receiver stalls while draining
        idle_on = 1'b0;
        // wait for every owed result, then for DRAIN_CYCLES more to catch strays
        while (names_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_top: errors");
        $finish;
    end

endmodule
